// ===== rtl/key_debounce_click_detector_assert.svh =====
// Assertion shorthands used by the debouncer lane RTL.
`ifndef KEY_DEBOUNCE_CLICK_DETECTOR_ASSERT_SVH
`define KEY_DEBOUNCE_CLICK_DETECTOR_ASSERT_SVH

// same-cycle implication
`define KDCD_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kdcd check failed");

// next-cycle implication
`define KDCD_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kdcd check failed");

`endif

// ===== rtl/kdcd_pkg.sv =====
package kdcd_pkg;

   localparam int NUM_KEYS  = 4;   // 1..4
   localparam int TIME_BITS = 32;  // 16..32

   localparam int MAX_KEYS       = 4;
   localparam int PIN_BITS       = 4;
   localparam int FIELD_BITS     = 32;
   localparam int RUN_BITS       = 4;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [FIELD_BITS-1:0]    field_type;
   typedef logic [RUN_BITS-1:0]      run_type;
   typedef logic [PIN_BITS-1:0]      pin_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   localparam csr_idx_type CSR_POLARITY    = 2'd0;
   localparam csr_idx_type CSR_DEBOUNCE    = 2'd1;
   localparam csr_idx_type CSR_CLICK_LIMIT = 2'd2;

   localparam pin_type   POLARITY_RESET    = 4'd8;
   localparam run_type   DEBOUNCE_RESET    = 4'd3;
   localparam field_type CLICK_LIMIT_RESET = 32'd800;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_INIT = 1'b1;

   // broadcast to every lane
   typedef struct packed {
      logic      fire;
      logic      init;
      time_type  now;
      run_type   debounce;
      field_type limit;
   } lane_cmd_type;

   // per-key state after the item, before the take mask
   typedef struct packed {
      logic     stable;
      logic     press;
      logic     release_ev;
      logic     click;
      time_type held;
   } lane_out_type;

endpackage

// ===== rtl/kdcd_req_if.sv =====
interface kdcd_req_if;
   import kdcd_pkg::*;
   logic      valid;
   logic      ready;
   logic      opcode;
   pin_type   pin_levels;
   field_type now_ms;
   pin_type   take_mask;

   modport source (output valid, opcode, pin_levels, now_ms, take_mask, input ready);
   modport sink   (input valid, opcode, pin_levels, now_ms, take_mask, output ready);
endinterface

// ===== rtl/kdcd_rsp_if.sv =====
interface kdcd_rsp_if;
   import kdcd_pkg::*;
   logic      valid;
   logic      ready;
   pin_type   pressed_levels;
   pin_type   press_events;
   pin_type   release_events;
   pin_type   click_events;
   field_type held_ms_key0;
   field_type held_ms_key1;
   field_type held_ms_key2;
   field_type held_ms_key3;

   modport source (output valid, pressed_levels, press_events, release_events,
                   click_events, held_ms_key0, held_ms_key1, held_ms_key2,
                   held_ms_key3, input ready);
   modport sink   (input valid, pressed_levels, press_events, release_events,
                   click_events, held_ms_key0, held_ms_key1, held_ms_key2,
                   held_ms_key3, output ready);
endinterface

// ===== rtl/kdcd_csr_if.sv =====
interface kdcd_csr_if;
   import kdcd_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/kdcd_lane.sv =====
`include "key_debounce_click_detector_assert.svh"

module kdcd_lane import kdcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lane_cmd_type cmd,
   input  logic         sample,
   input  logic         take,
   output lane_out_type result
);

   logic     stable_ff, stable_in;
   logic     prev_ff, prev_in;
   run_type  run_ff, run_in;
   time_type press_time_ff, press_time_in;
   logic     press_ff, press_in;
   logic     rel_ff, rel_in;
   logic     click_ff, click_in;
   time_type held_ff, held_in;
   time_type dur;
   run_type  run_step;
   logic     commit;

   always_comb begin
      dur      = cmd.now - press_time_ff;
      run_step = (run_ff < cmd.debounce) ? run_ff + 1'b1 : run_ff;
      stable_in     = stable_ff;
      prev_in       = prev_ff;
      run_in        = run_ff;
      press_time_in = press_time_ff;
      press_in      = press_ff;
      rel_in        = rel_ff;
      click_in      = click_ff;
      held_in       = held_ff;
      commit        = 1'b0;
      if (cmd.init) begin
         stable_in     = sample;
         prev_in       = sample;
         run_in        = '0;
         press_time_in = sample ? cmd.now : '0;
         press_in      = 1'b0;
         rel_in        = 1'b0;
         click_in      = 1'b0;
         held_in       = '0;
      end else begin
         prev_in = sample;
         run_in  = (sample == prev_ff) ? run_step : '0;
         commit  = (run_in >= cmd.debounce) && (sample != stable_ff);
         if (commit) begin
            stable_in = sample;
            if (sample) begin
               press_time_in = cmd.now;
               press_in      = 1'b1;
               held_in       = '0;
            end else begin
               rel_in   = 1'b1;
               click_in = (field_type'(dur) <= cmd.limit);
               held_in  = dur;
            end
         end
         // running hold time; a fresh press reads zero
         if (stable_in && !(commit && sample)) begin
            held_in = dur;
         end
      end
      result = '{stable: stable_in, press: press_in, release_ev: rel_in,
                 click: click_in, held: held_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff     <= 1'b0;
         prev_ff       <= 1'b0;
         run_ff        <= '0;
         press_time_ff <= '0;
         press_ff      <= 1'b0;
         rel_ff        <= 1'b0;
         click_ff      <= 1'b0;
         held_ff       <= '0;
      end else if (cmd.fire) begin
         stable_ff     <= stable_in;
         prev_ff       <= prev_in;
         run_ff        <= run_in;
         press_time_ff <= press_time_in;
         press_ff      <= press_in & ~take;
         rel_ff        <= rel_in & ~take;
         click_ff      <= click_in & ~take;
         held_ff       <= held_in;
      end
   end

   `KDCD_CHECK_NEXT(a_init_settles, cmd.fire && cmd.init, run_ff == '0 && prev_ff == stable_ff)
   `KDCD_CHECK_NEXT(a_idle_holds, !cmd.fire, $stable(stable_ff) && $stable(press_time_ff))
   `KDCD_CHECK_NEXT(a_press_stamps, cmd.fire && commit && sample, press_time_ff == $past(cmd.now))
   `KDCD_CHECK(a_commit_needs_run, commit, run_in >= cmd.debounce)

endmodule

// ===== rtl/kdcd_merge.sv =====
module kdcd_merge import kdcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  lane_out_type      lanes [NUM_KEYS],
   output logic              ready,
   kdcd_rsp_if.source        rsp_ch
);

   logic      valid_ff;
   pin_type   level_ff, level_in;
   pin_type   press_ff, press_in;
   pin_type   rel_ff, rel_in;
   pin_type   click_ff, click_in;
   field_type held_ff [MAX_KEYS];
   field_type held_in [MAX_KEYS];

   assign ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      level_in = '0;
      press_in = '0;
      rel_in   = '0;
      click_in = '0;
      for (int k = 0; k < MAX_KEYS; k++) begin
         held_in[k] = '0;
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
         level_in[k] = lanes[k].stable;
         press_in[k] = lanes[k].press;
         rel_in[k]   = lanes[k].release_ev;
         click_in[k] = lanes[k].click;
         held_in[k]  = field_type'(lanes[k].held);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         level_ff <= level_in;
         press_ff <= press_in;
         rel_ff   <= rel_in;
         click_ff <= click_in;
         held_ff  <= held_in;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.pressed_levels = level_ff;
   assign rsp_ch.press_events   = press_ff;
   assign rsp_ch.release_events = rel_ff;
   assign rsp_ch.click_events   = click_ff;
   assign rsp_ch.held_ms_key0   = held_ff[0];
   assign rsp_ch.held_ms_key1   = held_ff[1];
   assign rsp_ch.held_ms_key2   = held_ff[2];
   assign rsp_ch.held_ms_key3   = held_ff[3];

endmodule

// ===== rtl/key_debounce_click_detector.sv =====
// channel   dir  handshake      payload
// req_ch    in   valid/ready    opcode, pin_levels, now_ms, take_mask
// rsp_ch    out  valid/ready    pressed_levels, *_events, held_ms_key0..3
// csr_ch    in   valid/ready    index (0 polarity, 1 debounce, 2 click limit), data
//
// One transfer in per clock while not stalled, one result transfer out per item.
// Each key is a lane that updates its debounce state when the item is taken; the
// merge stage registers the result in a single output register.
// A new item is taken while that register is empty or being drained the same cycle;
// it stalls only while a result waits and rsp_ch.ready is low.
// Reset (synchronous) clears all per-key state and loads the register defaults;
// csr_ch is always ready.
module key_debounce_click_detector import kdcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   kdcd_req_if.sink   req_ch,
   kdcd_rsp_if.source rsp_ch,
   kdcd_csr_if.sink   csr_ch
);

   pin_type      polarity_ff;
   run_type      debounce_ff;
   field_type    limit_ff;
   logic         ready;
   logic         fire;
   pin_type      samples;
   lane_cmd_type cmd;
   lane_out_type lanes [NUM_KEYS];

   // configuration: to be written only while idle, so no hazard with lanes; the block does not enforce this
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= POLARITY_RESET;
         debounce_ff <= DEBOUNCE_RESET;
         limit_ff    <= CLICK_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_POLARITY:    polarity_ff <= pin_type'(csr_ch.data);
            CSR_DEBOUNCE:    debounce_ff <= run_type'(csr_ch.data);
            CSR_CLICK_LIMIT: limit_ff    <= field_type'(csr_ch.data);
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // input transfer
   assign req_ch.ready = ready;
   assign fire         = req_ch.valid && ready;

   // pressed sample: level matches the key's polarity bit
   assign samples = ~(req_ch.pin_levels ^ polarity_ff);

   assign cmd = '{fire: fire,
                  init: (req_ch.opcode == OP_INIT),
                  now: time_type'(req_ch.now_ms),
                  debounce: debounce_ff,
                  limit: limit_ff};

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kdcd_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .sample (samples[k]),
         .take   (req_ch.take_mask[k]),
         .result (lanes[k])
      );
   end

   // packs lane results, holds the output register
   kdcd_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .lanes  (lanes),
      .ready  (ready),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== dv/tb_key_debounce_click_detector.sv =====
module tb_key_debounce_click_detector;
   import kdcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Index 3 is outside the register list; the block must ignore writes to it.
   localparam csr_idx_type CSR_SPARE = 2'd3;

   // Cycles with no transfer on any channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;

   // One input item as the driver presents it.
   typedef struct packed {
      logic      opcode;
      pin_type   pin_levels;
      field_type now_ms;
      pin_type   take_mask;
   } key_sample_type;

   // One result item, field for field as the block reports it.
   typedef struct packed {
      pin_type                  levels;
      pin_type                  press_ev;
      pin_type                  rel_ev;
      pin_type                  click_ev;
      field_type [MAX_KEYS-1:0] held;
   } key_report_type;

   logic clock;
   logic reset;

   kdcd_req_if req_ch ();
   kdcd_rsp_if rsp_ch ();
   kdcd_csr_if csr_ch ();

   key_debounce_click_detector uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ---------------------------------------------------------------------
   // Predictor state: the testbench's own copy of the per-key debounce
   // state and of the three registers, updated at each accepted transfer.
   // ---------------------------------------------------------------------
   pin_type   pol_cfg   = POLARITY_RESET;
   run_type   deb_cfg   = DEBOUNCE_RESET;
   field_type limit_cfg = CLICK_LIMIT_RESET;

   logic [MAX_KEYS-1:0] stable_q;
   logic [MAX_KEYS-1:0] last_smp_q;
   logic [MAX_KEYS-1:0] press_ev_q;
   logic [MAX_KEYS-1:0] rel_ev_q;
   logic [MAX_KEYS-1:0] click_ev_q;
   run_type             run_q      [MAX_KEYS];
   time_type            press_at_q [MAX_KEYS];
   time_type            held_q     [MAX_KEYS];

   key_sample_type pending_samples[$];   // filled by the sequence, drained by the driver
   key_report_type expected_reports[$];  // one per accepted input transfer

   int unsigned items_in_flight = 0;  // queued but not yet answered
   int unsigned error_count     = 0;
   int unsigned quiet_cycles    = 0;

   // driver / receiver knobs, changed per phase by the sequence
   bit          gaps_on   = 1'b0;
   bit          stalls_on = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   logic [15:0] stall_bits = '1;
   logic [3:0]  stall_step = '0;

   bit        req_taken = 1'b0;  // input transfer at the last rising edge
   field_type now_track = '0;    // running millisecond clock for random traffic

   // Clock: 10 ns period.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor. Applies one sample to every key and returns the report the
   // block must give; the take mask clears event flags after reporting.
   // ---------------------------------------------------------------------
   function automatic key_report_type predict_key_report(key_sample_type s);
      key_report_type rep;
      logic           smp;
      time_type       stamp;
      time_type       dur;
      rep   = '0;
      stamp = time_type'(s.now_ms);
      for (int k = 0; k < NUM_KEYS; k++) begin
         // polarity bit set: high pin is pressed
         smp = pol_cfg[k] ? s.pin_levels[k] : ~s.pin_levels[k];
         if (s.opcode == OP_INIT) begin
            stable_q[k]   = smp;
            last_smp_q[k] = smp;
            run_q[k]      = '0;
            press_at_q[k] = smp ? stamp : '0;
            press_ev_q[k] = 1'b0;
            rel_ev_q[k]   = 1'b0;
            click_ev_q[k] = 1'b0;
            held_q[k]     = '0;
         end else begin
            // run saturates at the debounce count; a lowered count leaves it alone
            if (smp == last_smp_q[k]) begin
               if (run_q[k] < deb_cfg)
                  run_q[k] = run_q[k] + 1'b1;
            end else begin
               last_smp_q[k] = smp;
               run_q[k]      = '0;
            end
            if (run_q[k] >= deb_cfg && smp != stable_q[k]) begin
               stable_q[k] = smp;
               if (smp) begin
                  press_at_q[k] = stamp;
                  press_ev_q[k] = 1'b1;
                  held_q[k]     = '0;
               end else begin
                  dur           = stamp - press_at_q[k];  // wraps mod 2^TIME_BITS
                  rel_ev_q[k]   = 1'b1;
                  click_ev_q[k] = (field_type'(dur) <= limit_cfg);
                  held_q[k]     = dur;
               end
            end
            if (stable_q[k])
               held_q[k] = stamp - press_at_q[k];
         end
         rep.levels[k]   = stable_q[k];
         rep.press_ev[k] = press_ev_q[k];
         rep.rel_ev[k]   = rel_ev_q[k];
         rep.click_ev[k] = click_ev_q[k];
         rep.held[k]     = field_type'(held_q[k]);
         if (s.take_mask[k]) begin
            press_ev_q[k] = 1'b0;
            rel_ev_q[k]   = 1'b0;
            click_ev_q[k] = 1'b0;
         end
      end
      return rep;
   endfunction

   task automatic check_field(string name, field_type want, field_type got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Results are checked
   // before the new input transfer is predicted; a result never leaves in
   // the cycle its item is taken, so the order is safe.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      key_report_type got;
      key_report_type want;
      bit             rsp_taken;
      bit             csr_taken;
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         rsp_taken = rsp_ch.valid && rsp_ch.ready;
         csr_taken = csr_ch.valid && csr_ch.ready;
         req_taken = req_ch.valid && req_ch.ready;

         if (rsp_taken) begin
            got.levels   = rsp_ch.pressed_levels;
            got.press_ev = rsp_ch.press_events;
            got.rel_ev   = rsp_ch.release_events;
            got.click_ev = rsp_ch.click_events;
            got.held[0]  = rsp_ch.held_ms_key0;
            got.held[1]  = rsp_ch.held_ms_key1;
            got.held[2]  = rsp_ch.held_ms_key2;
            got.held[3]  = rsp_ch.held_ms_key3;
            if (expected_reports.size() == 0) begin
               $error("result transfer with no item outstanding");
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               items_in_flight--;
               check_field("pressed_levels", field_type'(want.levels),
                           field_type'(got.levels));
               check_field("press_events", field_type'(want.press_ev),
                           field_type'(got.press_ev));
               check_field("release_events", field_type'(want.rel_ev),
                           field_type'(got.rel_ev));
               check_field("click_events", field_type'(want.click_ev),
                           field_type'(got.click_ev));
               check_field("held_ms_key0", want.held[0], got.held[0]);
               check_field("held_ms_key1", want.held[1], got.held[1]);
               check_field("held_ms_key2", want.held[2], got.held[2]);
               check_field("held_ms_key3", want.held[3], got.held[3]);
            end
         end

         if (csr_taken) begin
            case (csr_ch.index)
               CSR_POLARITY:    pol_cfg   = csr_ch.data[PIN_BITS-1:0];
               CSR_DEBOUNCE:    deb_cfg   = csr_ch.data[RUN_BITS-1:0];
               CSR_CLICK_LIMIT: limit_cfg = csr_ch.data;
               default: ;  // spare index: no register behind it
            endcase
         end

         if (req_taken)
            expected_reports.push_back(predict_key_report('{
               opcode:     req_ch.opcode,
               pin_levels: req_ch.pin_levels,
               now_ms:     req_ch.now_ms,
               take_mask:  req_ch.take_mask}));

         // watchdog: any transfer on any channel counts as progress
         if (rsp_taken || csr_taken || req_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_key_debounce_click_detector: done, errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: changes the input channel at the falling edge. Items go out in
   // bursts; after each burst an optional gap of idle cycles follows.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      key_sample_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            next_item = pending_samples.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.opcode     <= next_item.opcode;
            req_ch.pin_levels <= next_item.pin_levels;
            req_ch.now_ms     <= next_item.now_ms;
            req_ch.take_mask  <= next_item.take_mask;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = gaps_on ? $urandom_range(0, 7) : 0;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready follows a 16-bit pattern, reloaded each time it rolls
   // over; a quarter of the patterns are all-ready stretches.
   always @(negedge clock) begin
      if (stall_step == 0)
         stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      rsp_ch.ready <= !stalls_on || stall_bits[stall_step];
      stall_step = stall_step + 1'b1;
   end

   task automatic queue_item(logic op, pin_type pins, field_type stamp, pin_type take);
      pending_samples.push_back('{opcode: op, pin_levels: pins, now_ms: stamp,
                                  take_mask: take});
      items_in_flight++;
   endtask

   // Block until every queued item has been answered, plus the pipeline latency.
   task automatic wait_idle();
      while (items_in_flight != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, csr_data_type val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
   endtask

   // All three registers plus the spare index; upper data bits of the
   // 4-bit registers carry junk that must be dropped.
   task automatic program_csrs(pin_type pol, run_type deb, field_type lim);
      csr_write(CSR_POLARITY, {28'($urandom), pol});
      csr_write(CSR_DEBOUNCE, {28'($urandom), deb});
      csr_write(CSR_CLICK_LIMIT, lim);
      csr_write(CSR_SPARE, $urandom);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random traffic: mostly held pin patterns long enough to pass the
   // debounce filter, with single-key bounces, some pure-noise bursts,
   // occasional re-init, and a clock that mostly creeps but sometimes jumps
   // or sits just below the wrap point.
   task automatic queue_key_traffic(int unsigned n_items);
      pin_type     target;
      pin_type     pins;
      pin_type     take;
      int unsigned hold;
      int unsigned left;
      bit          noisy;
      target = pin_type'($urandom);
      left   = n_items;
      while (left != 0) begin
         noisy  = ($urandom_range(0, 6) == 0);
         target = target ^ pin_type'($urandom);
         hold   = $urandom_range(1, int'(deb_cfg) + 6);
         while (hold != 0 && left != 0) begin
            pins = noisy ? pin_type'($urandom) : target;
            if (!noisy && $urandom_range(0, 11) == 0)
               pins = pins ^ pin_type'(1 << $urandom_range(0, 3));
            case ($urandom_range(0, 19))
               0:       now_track = $urandom;
               1:       now_track = 32'hFFFF_FFFF - $urandom_range(0, 40);
               2, 3, 4: now_track = now_track + $urandom_range(0, 3000);
               default: now_track = now_track + $urandom_range(0, 60);
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2: take = pin_type'($urandom);
               3:       take = 4'hF;
               default: take = 4'h0;
            endcase
            queue_item(($urandom_range(0, 59) == 0) ? OP_INIT : OP_TICK,
                       pins, now_track, take);
            hold--;
            left--;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_TICK;
      req_ch.pin_levels = '0;
      req_ch.now_ms     = '0;
      req_ch.take_mask  = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_POLARITY;
      csr_ch.data       = '0;
      stable_q   = '0;
      last_smp_q = '0;
      press_ev_q = '0;
      rel_ev_q   = '0;
      click_ev_q = '0;
      for (int k = 0; k < MAX_KEYS; k++) begin
         run_q[k]      = '0;
         press_at_q[k] = '0;
         held_q[k]     = '0;
      end

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed, reset config (key 3 active high, keys 0..2 active low,
      // debounce 3, click limit 800).
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      // init with keys 0..2 pressed at t=0
      queue_item(OP_INIT, 4'h0, 32'd0, 4'h0);
      // flip all pins: release of 0..2 (click) and press of 3 on the 4th sample,
      // take mask clears the flags right after they are reported
      queue_item(OP_TICK, 4'hF, 32'd100, 4'h0);
      queue_item(OP_TICK, 4'hF, 32'd101, 4'h0);
      queue_item(OP_TICK, 4'hF, 32'd102, 4'h0);
      queue_item(OP_TICK, 4'hF, 32'd103, 4'hF);
      queue_item(OP_TICK, 4'hF, 32'd106, 4'h0);
      // near the top of the time range: press 0..2, long hold on key 3 -> no click
      for (int i = 0; i < 4; i++)
         queue_item(OP_TICK, 4'h0, 32'hFFFF_FFF0 + i, 4'h0);
      // across the wrap: short holds on 0..2 still count as clicks
      for (int i = 0; i < 4; i++)
         queue_item(OP_TICK, 4'hF, 32'd3 + i, 4'h5);
      wait_idle();

      // Zero debounce count, all keys active high, zero click limit:
      // every change commits at once; a zero-length hold is the only click.
      program_csrs(4'hF, 4'd0, 32'd0);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      queue_item(OP_TICK, 4'h0, 32'd1000, 4'h0);
      queue_item(OP_TICK, 4'hF, 32'd1000, 4'h0);
      queue_item(OP_TICK, 4'h0, 32'd1000, 4'h0);
      queue_item(OP_TICK, 4'hF, 32'd1001, 4'h0);
      queue_item(OP_TICK, 4'h0, 32'd1003, 4'hF);
      wait_idle();

      // Debounce count lowered under a run in progress: four equal samples
      // toward a press with count 8, then count 2 commits on the next one.
      program_csrs(4'h0, 4'd8, 32'hFFFF_FFFF);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      for (int i = 0; i < 4; i++)
         queue_item(OP_TICK, 4'h0, 32'd2000 + i, 4'h0);
      wait_idle();
      program_csrs(4'h0, 4'd2, 32'hFFFF_FFFF);
      queue_item(OP_TICK, 4'h0, 32'd2010, 4'h0);
      // release after a long hold: still a click with the maximum limit
      for (int i = 0; i < 3; i++)
         queue_item(OP_TICK, 4'hF, 32'd9000 + i, 4'h0);
      wait_idle();

      // Random phases; the first two keep the idle-free extremes apart.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               program_csrs(pin_type'($urandom), 4'd3, 32'd800);
               gaps_on = 1'b1; stalls_on = 1'b1;
            end
            1: begin
               program_csrs(4'h0, 4'd0, 32'd0);
               gaps_on = 1'b0; stalls_on = 1'b0;
            end
            2: begin
               program_csrs(4'hF, 4'd15, 32'hFFFF_FFFF);
               gaps_on = 1'b1; stalls_on = 1'b1;
            end
            3: begin
               program_csrs(pin_type'($urandom), run_type'($urandom), $urandom_range(0, 500));
               gaps_on = 1'b1; stalls_on = 1'b0;
            end
            4: begin
               program_csrs(pin_type'($urandom), 4'd1, $urandom);
               gaps_on = 1'b0; stalls_on = 1'b1;
            end
            default: begin
               program_csrs(pin_type'($urandom), run_type'($urandom), $urandom_range(0, 3000));
               gaps_on = 1'b1; stalls_on = 1'b1;
            end
         endcase
         queue_key_traffic(250);
         wait_idle();
      end

      if (error_count == 0)
         $display("tb_key_debounce_click_detector: done, clean");
      else
         $display("tb_key_debounce_click_detector: done, errors");
      $finish;
   end

endmodule

// ===== key_debounce_click_detector.f =====
+incdir+rtl
rtl/kdcd_pkg.sv
rtl/kdcd_req_if.sv
rtl/kdcd_rsp_if.sv
rtl/kdcd_csr_if.sv
rtl/kdcd_lane.sv
rtl/kdcd_merge.sv
rtl/key_debounce_click_detector.sv
dv/tb_key_debounce_click_detector.sv
